@@ rtl/core/lfra_pkg.sv @@
package lfra_pkg;

    // Recycle heap geometry.
    localparam int HEAP_DEPTH = 256;
    localparam int ADDR_W     = 8;
    localparam int CNT_W      = 9;
    localparam int SERIAL_W   = 8;
    localparam int STATUS_W   = 2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HEAP_FULL = 2'd2;

    // Request kinds carried on the input channel.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_GRANT_HW,
        CMD_EXHAUST,
        CMD_FULL,
        CMD_PUSH,
        CMD_POP_RD,
        CMD_POP_TAKE,
        CMD_DN_RD,
        CMD_DN_STEP,
        CMD_UP_RD,
        CMD_UP_STEP
    } lfra_cmd_t;

    typedef struct packed {
        lfra_cmd_t cmd;
        logic      load_out;
    } lfra_ctrl_t;

    typedef struct packed {
        logic op_free;
        logic heap_empty;
        logic heap_full;
        logic hw_exhausted;
        logic node_root;
        logic dn_done;
        logic up_done;
    } lfra_stat_t;

endpackage

@@ rtl/core/lfra_ctrl.sv @@
module lfra_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  lfra_pkg::lfra_stat_t stat,
    output lfra_pkg::lfra_ctrl_t ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_DN_RD,
        S_DN_EV,
        S_UP_CHK,
        S_UP_EV,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        s_tready_next = s_tready_reg;
        m_tvalid_next = m_tvalid_reg;
        ctrl.cmd      = lfra_pkg::CMD_NONE;
        ctrl.load_out = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    ctrl.cmd      = lfra_pkg::CMD_LOAD;
                    s_tready_next = 1'b0;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!stat.op_free) begin
                    if (!stat.heap_empty) begin
                        ctrl.cmd   = lfra_pkg::CMD_POP_RD;
                        state_next = S_POP;
                    end else if (stat.hw_exhausted) begin
                        ctrl.cmd   = lfra_pkg::CMD_EXHAUST;
                        state_next = S_FINISH;
                    end else begin
                        ctrl.cmd   = lfra_pkg::CMD_GRANT_HW;
                        state_next = S_FINISH;
                    end
                end else if (stat.heap_full) begin
                    ctrl.cmd   = lfra_pkg::CMD_FULL;
                    state_next = S_FINISH;
                end else begin
                    ctrl.cmd   = lfra_pkg::CMD_PUSH;
                    state_next = S_UP_CHK;
                end
            end
            S_POP: begin
                ctrl.cmd   = lfra_pkg::CMD_POP_TAKE;
                state_next = S_DN_RD;
            end
            S_DN_RD: begin
                ctrl.cmd   = lfra_pkg::CMD_DN_RD;
                state_next = S_DN_EV;
            end
            S_DN_EV: begin
                ctrl.cmd   = lfra_pkg::CMD_DN_STEP;
                state_next = stat.dn_done ? S_FINISH : S_DN_RD;
            end
            S_UP_CHK: begin
                if (stat.node_root) begin
                    ctrl.cmd   = lfra_pkg::CMD_UP_STEP;
                    state_next = S_FINISH;
                end else begin
                    ctrl.cmd   = lfra_pkg::CMD_UP_RD;
                    state_next = S_UP_EV;
                end
            end
            S_UP_EV: begin
                ctrl.cmd   = lfra_pkg::CMD_UP_STEP;
                state_next = stat.up_done ? S_FINISH : S_UP_CHK;
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    ctrl.load_out = 1'b1;
                    m_tvalid_next = 1'b1;
                    s_tready_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

@@ rtl/core/lfra_dp.sv @@
module lfra_dp #(
    parameter int REG_COUNT = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lfra_pkg::lfra_ctrl_t                ctrl,
    output lfra_pkg::lfra_stat_t                stat,
    input  logic                                in_op,
    input  logic [lfra_pkg::SERIAL_W-1:0]       in_serial,
    output logic [lfra_pkg::SERIAL_W-1:0]       out_serial,
    output logic [lfra_pkg::STATUS_W-1:0]       out_status
);

    localparam int HW_W = $clog2(REG_COUNT + 1);

    // Heap storage: one write port, two registered read ports.
    logic [lfra_pkg::SERIAL_W-1:0] heap_mem [lfra_pkg::HEAP_DEPTH];

    logic [lfra_pkg::ADDR_W-1:0]   rd_addr_a, rd_addr_b;
    logic [lfra_pkg::SERIAL_W-1:0] rd_data_a_reg, rd_data_b_reg;
    logic                          wr_en;
    logic [lfra_pkg::ADDR_W-1:0]   wr_addr;
    logic [lfra_pkg::SERIAL_W-1:0] wr_data;

    logic                          op_reg;
    logic [lfra_pkg::SERIAL_W-1:0] val_reg, val_next;
    logic [lfra_pkg::ADDR_W-1:0]   node_reg, node_next;
    logic [lfra_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [HW_W-1:0]               hw_reg, hw_next;
    logic [lfra_pkg::SERIAL_W-1:0] res_serial_reg, res_serial_next;
    logic [lfra_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [lfra_pkg::SERIAL_W-1:0] out_serial_reg;
    logic [lfra_pkg::STATUS_W-1:0] out_status_reg;

    // Sift-down and sift-up decisions.
    logic [lfra_pkg::CNT_W-1:0]    left_idx;
    logic [lfra_pkg::CNT_W:0]      right_idx;
    logic [lfra_pkg::CNT_W:0]      count_ext;
    logic                          left_ok, right_ok;
    logic [lfra_pkg::SERIAL_W-1:0] min_left;
    logic [lfra_pkg::ADDR_W-1:0]   least_idx;
    logic [lfra_pkg::SERIAL_W-1:0] least_val;
    logic [lfra_pkg::ADDR_W-1:0]   parent_idx;

    assign left_idx   = {node_reg, 1'b1};
    assign right_idx  = {1'b0, node_reg, 1'b1} + (lfra_pkg::CNT_W + 1)'(1);
    assign count_ext  = {1'b0, count_reg};
    assign left_ok    = (left_idx < count_reg) && (rd_data_a_reg < val_reg);
    assign min_left   = left_ok ? rd_data_a_reg : val_reg;
    assign right_ok   = (right_idx < count_ext) && (rd_data_b_reg < min_left);
    assign least_idx  = right_ok ? right_idx[lfra_pkg::ADDR_W-1:0]
                                 : left_idx[lfra_pkg::ADDR_W-1:0];
    assign least_val  = right_ok ? rd_data_b_reg : rd_data_a_reg;
    assign parent_idx = (node_reg - lfra_pkg::ADDR_W'(1)) >> 1;

    assign stat.op_free      = (op_reg == lfra_pkg::OP_FREE);
    assign stat.heap_empty   = (count_reg == '0);
    assign stat.heap_full    = (count_reg == lfra_pkg::CNT_W'(lfra_pkg::HEAP_DEPTH));
    assign stat.hw_exhausted = (hw_reg >= HW_W'(REG_COUNT));
    assign stat.node_root    = (node_reg == '0);
    assign stat.dn_done      = !left_ok && !right_ok;
    assign stat.up_done      = (node_reg == '0) || !(val_reg < rd_data_a_reg);

    always_comb begin
        rd_addr_a       = '0;
        rd_addr_b       = '0;
        wr_en           = 1'b0;
        wr_addr         = node_reg;
        wr_data         = val_reg;
        val_next        = val_reg;
        node_next       = node_reg;
        count_next      = count_reg;
        hw_next         = hw_reg;
        res_serial_next = res_serial_reg;
        res_status_next = res_status_reg;

        case (ctrl.cmd)
            lfra_pkg::CMD_LOAD: begin
                val_next = in_serial;
            end
            lfra_pkg::CMD_GRANT_HW: begin
                res_serial_next = lfra_pkg::SERIAL_W'(hw_reg);
                res_status_next = lfra_pkg::ST_OK;
                hw_next         = hw_reg + HW_W'(1);
            end
            lfra_pkg::CMD_EXHAUST: begin
                res_serial_next = '0;
                res_status_next = lfra_pkg::ST_EXHAUSTED;
            end
            lfra_pkg::CMD_FULL: begin
                res_serial_next = '0;
                res_status_next = lfra_pkg::ST_HEAP_FULL;
            end
            lfra_pkg::CMD_PUSH: begin
                node_next       = count_reg[lfra_pkg::ADDR_W-1:0];
                count_next      = count_reg + lfra_pkg::CNT_W'(1);
                res_serial_next = '0;
                res_status_next = lfra_pkg::ST_OK;
            end
            lfra_pkg::CMD_POP_RD: begin
                rd_addr_a = '0;
                rd_addr_b = count_reg[lfra_pkg::ADDR_W-1:0] - lfra_pkg::ADDR_W'(1);
            end
            lfra_pkg::CMD_POP_TAKE: begin
                res_serial_next = rd_data_a_reg;
                res_status_next = lfra_pkg::ST_OK;
                val_next        = rd_data_b_reg;
                count_next      = count_reg - lfra_pkg::CNT_W'(1);
                node_next       = '0;
            end
            lfra_pkg::CMD_DN_RD: begin
                rd_addr_a = left_idx[lfra_pkg::ADDR_W-1:0];
                rd_addr_b = right_idx[lfra_pkg::ADDR_W-1:0];
            end
            lfra_pkg::CMD_DN_STEP: begin
                wr_en = 1'b1;
                if (!stat.dn_done) begin
                    wr_data   = least_val;
                    node_next = least_idx;
                end
            end
            lfra_pkg::CMD_UP_RD: begin
                rd_addr_a = parent_idx;
            end
            lfra_pkg::CMD_UP_STEP: begin
                wr_en = 1'b1;
                if (!stat.up_done) begin
                    wr_data   = rd_data_a_reg;
                    node_next = parent_idx;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= heap_mem[rd_addr_a];
        rd_data_b_reg <= heap_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            hw_reg    <= '0;
        end else begin
            count_reg <= count_next;
            hw_reg    <= hw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cmd == lfra_pkg::CMD_LOAD) begin
            op_reg <= in_op;
        end
        val_reg        <= val_next;
        node_reg       <= node_next;
        res_serial_reg <= res_serial_next;
        res_status_reg <= res_status_next;
        if (ctrl.load_out) begin
            out_serial_reg <= res_serial_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_serial = out_serial_reg;
    assign out_status = out_status_reg;

endmodule

@@ rtl/core/lowest_free_register_allocator.sv @@
// Lowest-free register allocator. Each input transfer is either an allocate
// (s_tuser = 0) or a free of the register number in s_tdata (s_tuser = 1), and
// each produces exactly one result transfer carrying the granted number and a
// status (ok, all registers exhausted, or recycle heap full). Allocate returns
// the smallest freed number held in a 256-entry binary min-heap, and falls back
// to a high-water counter of never-used numbers below REG_COUNT. One request is
// processed at a time. A heap push needs no final read when the entry climbs
// all the way to the root. A heap pop always reads and compares the last
// level, even when the entry stays put. The entry moves at most 8 levels on
// a push and at most 7 on a pop. Each level first reads the parent or both
// children from the heap memory, then compares and writes the entry back.
// The heap memory needs no clearing after reset, and a free of a number that
// is already free is not checked.
module lowest_free_register_allocator #(
    parameter int REG_COUNT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] reg_serial
    input  logic [0:0]  s_tuser,   // [0] operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] granted_serial, [9:8] status, [15:10] zero
);

    lfra_pkg::lfra_ctrl_t ctrl;
    lfra_pkg::lfra_stat_t stat;

    logic [lfra_pkg::SERIAL_W-1:0] out_serial;
    logic [lfra_pkg::STATUS_W-1:0] out_status;

    // The controller sequences the heap walk; the datapath owns the heap
    // memory, the counters and the result registers.
    lfra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    lfra_dp #(
        .REG_COUNT (REG_COUNT)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .stat       (stat),
        .in_op      (s_tuser[0]),
        .in_serial  (s_tdata),
        .out_serial (out_serial),
        .out_status (out_status)
    );

    // The result payload is held in a register, so the next request can be
    // accepted while a result still waits for its transfer.
    assign m_tdata = {6'b0, out_status, out_serial};

endmodule
